@@ rtl/euclid_gcd_unit_macros.svh @@
// assertion macros used by the checker file
`ifndef EUCLID_GCD_UNIT_MACROS_SVH
`define EUCLID_GCD_UNIT_MACROS_SVH

// property must hold in the same cycle as its trigger
`define EGCD_ASSERT_NOW(lbl, clk, rst_n, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("egcd check failed");

// property must hold in the cycle after its trigger
`define EGCD_ASSERT_NEXT(lbl, clk, rst_n, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("egcd check failed");

`endif

@@ rtl/egcd_pkg.sv @@
package egcd_pkg;

  localparam int WIDTH = 32;
  localparam int KW    = $clog2(WIDTH);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SUB_A,
    OP_SUB_B,
    OP_FINISH
  } egcd_op_e;

  typedef struct packed {
    logic any_zero;
    logic equal;
    logic a_even;
    logic b_even;
    logic a_gt_b;
  } egcd_status_t;

  // unsigned magnitude; the most negative value maps to 2^(WIDTH-1)
  function automatic logic [WIDTH-1:0] magnitude(input logic [WIDTH-1:0] v);
    magnitude = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
  endfunction

endpackage

@@ rtl/egcd_datapath.sv @@
module egcd_datapath (
  input  logic                     clk_i,
  input  egcd_pkg::egcd_op_e       op_i,
  input  logic [egcd_pkg::WIDTH-1:0] operand_a_i,
  input  logic [egcd_pkg::WIDTH-1:0] operand_b_i,
  output egcd_pkg::egcd_status_t   status_o,
  output logic [egcd_pkg::WIDTH-1:0] divisor_out_o
);
  import egcd_pkg::*;

  logic [WIDTH-1:0] a_q, b_q, res_q;
  logic [KW-1:0]    k_q;
  logic [WIDTH-1:0] a_minus_b, b_minus_a;

  assign a_minus_b = a_q - b_q;
  assign b_minus_a = b_q - a_q;

  assign status_o.any_zero = (a_q == '0) || (b_q == '0);
  assign status_o.equal    = (a_q == b_q);
  assign status_o.a_even   = ~a_q[0];
  assign status_o.b_even   = ~b_q[0];
  assign status_o.a_gt_b   = (a_q > b_q);

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        a_q <= magnitude(operand_a_i);
        b_q <= magnitude(operand_b_i);
        k_q <= '0;
      end
      // common factor of two, restored at the end
      OP_HALVE_BOTH: begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + KW'(1);
      end
      OP_HALVE_A: a_q <= a_q >> 1;
      OP_HALVE_B: b_q <= b_q >> 1;
      // both odd: difference is even, halve it right away
      OP_SUB_A:   a_q <= a_minus_b >> 1;
      OP_SUB_B:   b_q <= b_minus_a >> 1;
      OP_FINISH: begin
        if ((a_q == '0) || (b_q == '0)) begin
          res_q <= a_q | b_q;
        end else begin
          res_q <= a_q << k_q;
        end
      end
      default: ;
    endcase
  end

  assign divisor_out_o = res_q;

endmodule

@@ rtl/egcd_ctrl.sv @@
module egcd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  egcd_pkg::egcd_status_t status_i,
  output egcd_pkg::egcd_op_e     op_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import egcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (start_i) begin
          op_o    = OP_LOAD;
          state_d = ST_RUN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (status_i.any_zero || status_i.equal) begin
          op_o    = OP_FINISH;
          state_d = ST_DONE;
        end else if (status_i.a_even && status_i.b_even) begin
          op_o = OP_HALVE_BOTH;
        end else if (status_i.a_even) begin
          op_o = OP_HALVE_A;
        end else if (status_i.b_even) begin
          op_o = OP_HALVE_B;
        end else if (status_i.a_gt_b) begin
          op_o = OP_SUB_A;
        end else begin
          op_o = OP_SUB_B;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q == ST_RUN);
  assign done_o = (state_q == ST_DONE);

endmodule

@@ rtl/euclid_gcd_unit.sv @@
// channel   | direction | handshake            | payload
// operands  | in        | start, busy          | operand_a_i, operand_b_i
// result    | out       | done_o (one cycle)   | divisor_out_o
//
// an item is loaded in the cycle start is taken, then the binary gcd loop
// retires one halving or subtract-and-halve step per cycle on a pair of
// subtractors, followed by a final shift step
// done_o pulses for one cycle; a new item may start in that same cycle
// reset is asynchronous, active low, and returns the controller to idle
// the result cannot be stalled, it must be taken while done_o is high
module euclid_gcd_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [egcd_pkg::WIDTH-1:0] operand_a_i,
  input  logic [egcd_pkg::WIDTH-1:0] operand_b_i,
  output logic                       done_o,
  output logic [egcd_pkg::WIDTH-1:0] divisor_out_o
);
  import egcd_pkg::*;

  egcd_op_e     op;
  egcd_status_t status;

  egcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  egcd_datapath u_datapath (
    .clk_i         (clk_i),
    .op_i          (op),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .status_o      (status),
    .divisor_out_o (divisor_out_o)
  );

endmodule

@@ rtl/egcd_checker.sv @@
`include "euclid_gcd_unit_macros.svh"

module egcd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  `EGCD_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `EGCD_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, done_o, !busy)
  `EGCD_ASSERT_NOW(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  `EGCD_ASSERT_NOW(a_busy_ends_done, clk_i, rst_ni, $fell(busy), done_o)
  `EGCD_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

bind euclid_gcd_unit egcd_checker u_egcd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);
